// File: design/fsms_pkg.sv
// fsms_pkg: shared types and constants for the flow-shop makespan evaluator
// used by fsms_ctrl, fsms_alu and flow_shop_makespan_with_setups_core
`timescale 1ns / 1ps

package fsms_pkg;

  localparam int BYTE_W       = 8;
  localparam int NUM_PROC     = 8;
  localparam int SETUP_W      = 16;
  localparam int MAKESPAN_W   = 24;
  localparam int TYPE_W       = 8;
  localparam int COUNT_W      = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 64;
  localparam int IN_DATA_W    = TYPE_W + NUM_PROC * BYTE_W;

  localparam logic [CFG_IDX_W-1:0] REG_MACHINES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETUPS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR   = 2'd2;

  localparam logic [COUNT_W-1:0] MACHINES_RST = 4'd8;
  localparam logic [BYTE_W-1:0]  FACTOR_RST   = 8'd10;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic last_step;
    logic emit;
  } ctrl_t;

endpackage

// File: design/fsms_ctrl.sv
// fsms_ctrl: sequencer that walks the machines of one job, one per cycle
// depends on fsms_pkg
`timescale 1ns / 1ps

module fsms_ctrl #(
  parameter int MAX_MACHINES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_fire,
  input  logic                              out_free,
  input  logic [$clog2(MAX_MACHINES)-1:0]   last_idx,
  output logic                              in_ready,
  output fsms_pkg::ctrl_t                   ctrl,
  output logic [$clog2(MAX_MACHINES)-1:0]   idx,
  output logic [$clog2(MAX_MACHINES)-1:0]   setup_idx
);

  localparam int IDX_W = $clog2(MAX_MACHINES);

  fsms_pkg::state_t  state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, last_r;
  logic              at_last;

  assign at_last = (idx_r == last_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fsms_pkg::S_IDLE: if (in_fire) state_nxt = fsms_pkg::S_RUN;
      fsms_pkg::S_RUN:  if (at_last) state_nxt = fsms_pkg::S_EMIT;
      fsms_pkg::S_EMIT: if (out_free) state_nxt = fsms_pkg::S_IDLE;
      default:          state_nxt = fsms_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    ctrl           = '0;
    setup_idx      = '0;
    unique case (state_r)
      fsms_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_fire;
      end
      fsms_pkg::S_RUN: begin
        ctrl.step      = 1'b1;
        ctrl.last_step = at_last;
        if (!at_last) setup_idx = idx_r + 1'b1;
      end
      fsms_pkg::S_EMIT: begin
        ctrl.emit = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign idx = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsms_pkg::S_IDLE;
      idx_r   <= '0;
      last_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (ctrl.load) begin
        idx_r  <= '0;
        last_r <= last_idx;
      end else if (ctrl.step && !at_last) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

endmodule

// File: design/fsms_alu.sv
// fsms_alu: shared step unit, setup multiply plus start/finish add and compare
// depends on fsms_pkg
`timescale 1ns / 1ps

module fsms_alu #(
  parameter int TIME_WIDTH = 24
) (
  input  logic [fsms_pkg::BYTE_W-1:0]  base,
  input  logic [fsms_pkg::BYTE_W-1:0]  factor,
  input  logic                         changed,
  output logic [fsms_pkg::SETUP_W-1:0] setup,
  input  logic [fsms_pkg::SETUP_W-1:0] setup_in,
  input  logic [TIME_WIDTH-1:0]        finish,
  input  logic [TIME_WIDTH-1:0]        upstream,
  input  logic [fsms_pkg::BYTE_W-1:0]  proc,
  output logic [TIME_WIDTH-1:0]        finish_new,
  output logic                         sat
);

  logic [TIME_WIDTH:0]   ready_sum, start_sum;
  logic [TIME_WIDTH+1:0] end_sum;

  // setup for the next machine, registered outside before use
  assign setup = changed ? (fsms_pkg::SETUP_W'(base) * fsms_pkg::SETUP_W'(factor))
                         : fsms_pkg::SETUP_W'(base);

  assign ready_sum = (TIME_WIDTH+1)'(finish) + (TIME_WIDTH+1)'(setup_in);
  assign start_sum = (ready_sum > (TIME_WIDTH+1)'(upstream)) ? ready_sum
                                                             : (TIME_WIDTH+1)'(upstream);
  assign end_sum   = (TIME_WIDTH+2)'(start_sum) + (TIME_WIDTH+2)'(proc);
  assign sat       = |end_sum[TIME_WIDTH+1:TIME_WIDTH];
  assign finish_new = sat ? {TIME_WIDTH{1'b1}} : end_sum[TIME_WIDTH-1:0];

endmodule

// File: design/flow_shop_makespan_with_setups_core.sv
// Flow-shop makespan evaluator with setup times. Each job item walks the machines in use
// one per cycle through a single shared step unit; the per-machine chain is what sets the
// timing. After accept the block steps through the machines in use in its run state, then
// an emit step loads the result register; the next item can be taken once it is loaded.
// in_tready is low from accept until the result has been loaded, and a result still
// waiting on out_tready holds the block in its emit step. The setup multiply for the next
// machine runs in the step before its use, through a register. Configuration is taken at
// any time on the cfg channel and must only be written while the block is idle.
// top level, depends on fsms_pkg, fsms_ctrl and fsms_alu
`timescale 1ns / 1ps

module flow_shop_makespan_with_setups_core #(
  parameter int MAX_MACHINES = 8,
  parameter int TIME_WIDTH   = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // job_type, proc_time_m0 .. proc_time_m7
  input  logic [fsms_pkg::IN_DATA_W-1:0]    in_tdata,
  // start_schedule
  input  logic [0:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // makespan
  output logic [fsms_pkg::MAKESPAN_W-1:0]   out_tdata,
  // overflow
  output logic [0:0]                        out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fsms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fsms_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = $clog2(MAX_MACHINES);
  localparam int BW    = fsms_pkg::BYTE_W;

  logic [fsms_pkg::COUNT_W-1:0]  machines_r;
  logic [BW-1:0]                 setup_base_r [MAX_MACHINES];
  logic [BW-1:0]                 factor_r;

  logic [TIME_WIDTH-1:0]         fin_r [MAX_MACHINES];
  logic [fsms_pkg::TYPE_W-1:0]   prev_type_r;
  logic                          have_r;
  logic [TIME_WIDTH-1:0]         mk_r;
  logic                          sat_r;

  logic [BW-1:0]                 proc_r [MAX_MACHINES];
  logic                          changed_r;
  logic [fsms_pkg::SETUP_W-1:0]  setup_r;
  logic [TIME_WIDTH-1:0]         upstream_r;

  logic                          out_tvalid_r;
  logic [fsms_pkg::MAKESPAN_W-1:0] out_tdata_r;
  logic                          out_tuser_r;

  logic                          in_fire, out_free, start, changed_now;
  logic [fsms_pkg::TYPE_W-1:0]   jtype;
  logic [IDX_W-1:0]              last_idx, idx, setup_idx;
  fsms_pkg::ctrl_t               ctrl;
  logic [fsms_pkg::SETUP_W-1:0]  alu_setup;
  logic [TIME_WIDTH-1:0]         alu_finish;
  logic                          alu_sat;
  logic [TIME_WIDTH+fsms_pkg::MAKESPAN_W-1:0] mk_ext;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid & in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign start     = in_tuser[0];
  assign jtype     = in_tdata[fsms_pkg::TYPE_W-1:0];
  assign changed_now = !start && have_r && (prev_type_r != jtype);

  // clamp machine count to 1..MAX_MACHINES, as a last index
  always_comb begin
    priority if (machines_r == '0)
      last_idx = '0;
    else if (machines_r > fsms_pkg::COUNT_W'(MAX_MACHINES))
      last_idx = IDX_W'(MAX_MACHINES - 1);
    else
      last_idx = IDX_W'(machines_r - 1'b1);
  end

  fsms_ctrl #(.MAX_MACHINES(MAX_MACHINES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .out_free  (out_free),
    .last_idx  (last_idx),
    .in_ready  (in_tready),
    .ctrl      (ctrl),
    .idx       (idx),
    .setup_idx (setup_idx)
  );

  fsms_alu #(.TIME_WIDTH(TIME_WIDTH)) u_alu (
    .base       (setup_base_r[setup_idx]),
    .factor     (factor_r),
    .changed    (ctrl.load ? changed_now : changed_r),
    .setup      (alu_setup),
    .setup_in   (setup_r),
    .finish     (fin_r[idx]),
    .upstream   (upstream_r),
    .proc       (proc_r[idx]),
    .finish_new (alu_finish),
    .sat        (alu_sat)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      machines_r <= fsms_pkg::MACHINES_RST;
      factor_r   <= fsms_pkg::FACTOR_RST;
      for (int m = 0; m < MAX_MACHINES; m++) setup_base_r[m] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fsms_pkg::REG_MACHINES: machines_r <= cfg_data[fsms_pkg::COUNT_W-1:0];
        fsms_pkg::REG_SETUPS: begin
          for (int m = 0; m < MAX_MACHINES; m++) setup_base_r[m] <= cfg_data[BW*m +: BW];
        end
        fsms_pkg::REG_FACTOR:   factor_r <= cfg_data[BW-1:0];
        default:                factor_r <= factor_r;
      endcase
    end
  end

  // schedule state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < MAX_MACHINES; m++) fin_r[m] <= '0;
      prev_type_r <= '0;
      have_r      <= 1'b0;
      mk_r        <= '0;
      sat_r       <= 1'b0;
    end else if (ctrl.load) begin
      if (start) begin
        for (int m = 0; m < MAX_MACHINES; m++) fin_r[m] <= '0;
        mk_r  <= '0;
        sat_r <= 1'b0;
      end
      prev_type_r <= jtype;
      have_r      <= 1'b1;
    end else if (ctrl.step) begin
      fin_r[idx] <= alu_finish;
      if (alu_sat) sat_r <= 1'b1;
      if (ctrl.last_step && (alu_finish > mk_r)) mk_r <= alu_finish;
    end
  end

  // per-job working registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int m = 0; m < MAX_MACHINES; m++)
        proc_r[m] <= in_tdata[fsms_pkg::TYPE_W + BW*m +: BW];
      changed_r  <= changed_now;
      setup_r    <= alu_setup;
      upstream_r <= '0;
    end else if (ctrl.step) begin
      setup_r    <= alu_setup;
      upstream_r <= alu_finish;
    end
  end

  assign mk_ext = {{fsms_pkg::MAKESPAN_W{1'b0}}, mk_r};

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_tdata_r <= mk_ext[fsms_pkg::MAKESPAN_W-1:0];
      out_tuser_r <= sat_r;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_tuser_r;

endmodule

// File: tb/tb_top.sv
// tb_top: self-checking bench for flow_shop_makespan_with_setups_core, predicts the running
// makespan and overflow of every job item and compares them with the result stream
// depends on fsms_pkg and the core
`timescale 1ns / 1ps

module tb_top;

  localparam logic [fsms_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [63:0] TIME_CEIL = (64'd1 << fsms_pkg::MAKESPAN_W) - 64'd1;

  typedef struct packed {
    logic                                                start;
    logic [fsms_pkg::TYPE_W-1:0]                         jtype;
    logic [fsms_pkg::NUM_PROC-1:0][fsms_pkg::BYTE_W-1:0] proc;
  } job_t;

  typedef struct packed {
    logic [fsms_pkg::MAKESPAN_W-1:0] makespan;
    logic                            overflow;
  } span_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [fsms_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [0:0]                      in_tuser;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [fsms_pkg::MAKESPAN_W-1:0] out_tdata;
  logic [0:0]                      out_tuser;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [fsms_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fsms_pkg::CFG_DATA_W-1:0] cfg_data;

  flow_shop_makespan_with_setups_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow configuration and schedule state
  logic [fsms_pkg::COUNT_W-1:0]    cfg_machines;
  logic [fsms_pkg::CFG_DATA_W-1:0] cfg_setups;
  logic [fsms_pkg::BYTE_W-1:0]     cfg_factor;
  logic [fsms_pkg::MAKESPAN_W-1:0] line_finish [fsms_pkg::NUM_PROC];
  logic [fsms_pkg::TYPE_W-1:0]     last_type;
  logic                            have_last;
  logic [fsms_pkg::MAKESPAN_W-1:0] span_so_far;
  logic                            sat_seen;

  span_t expected_spans[$];
  int    error_count = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  logic  hold_req = 1'b0;
  int    hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("flow_shop_makespan_with_setups_core test failed");
    $finish;
  end

  function automatic void clear_line();
    for (int m = 0; m < fsms_pkg::NUM_PROC; m++) line_finish[m] = '0;
    last_type   = '0;
    have_last   = 1'b0;
    span_so_far = '0;
    sat_seen    = 1'b0;
  endfunction

  function automatic span_t predict_span(job_t j);
    int          count;
    logic        changed;
    logic [63:0] base;
    logic [63:0] setup;
    logic [63:0] ready;
    logic [63:0] upstream;
    logic [63:0] start_at;
    logic [63:0] finish;
    span_t       r;
    if (j.start) clear_line();
    count = int'(cfg_machines);
    if (count < 1) count = 1;
    if (count > fsms_pkg::NUM_PROC) count = fsms_pkg::NUM_PROC;
    changed = have_last && (last_type != j.jtype);
    for (int m = 0; m < count; m++) begin
      base     = 64'(cfg_setups[m*fsms_pkg::BYTE_W +: fsms_pkg::BYTE_W]);
      setup    = changed ? base * 64'(cfg_factor) : base;
      ready    = 64'(line_finish[m]) + setup;
      upstream = (m > 0) ? 64'(line_finish[m-1]) : 64'd0;
      start_at = (ready > upstream) ? ready : upstream;
      finish   = start_at + 64'(j.proc[m]);
      if (finish > TIME_CEIL) begin
        finish   = TIME_CEIL;
        sat_seen = 1'b1;
      end
      line_finish[m] = finish[fsms_pkg::MAKESPAN_W-1:0];
    end
    if (line_finish[count-1] > span_so_far) span_so_far = line_finish[count-1];
    last_type  = j.jtype;
    have_last  = 1'b1;
    r.makespan = span_so_far;
    r.overflow = sat_seen;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    span_t exp_span;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (expected_spans.size() == 0) begin
        $error("unexpected result item: makespan %0d overflow %0d", out_tdata, out_tuser);
        error_count++;
      end else begin
        exp_span = expected_spans.pop_front();
        if (out_tdata !== exp_span.makespan) begin
          $error("makespan mismatch: expected %0d, actual %0d", exp_span.makespan, out_tdata);
          error_count++;
        end
        if (out_tuser[0] !== exp_span.overflow) begin
          $error("overflow mismatch: expected %0d, actual %0d", exp_span.overflow, out_tuser);
          error_count++;
        end
      end
    end
  end

  // result-side ready, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_job(job_t j);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {j.proc, j.jtype};
    in_tuser  <= j.start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_spans.push_back(predict_span(j));
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_spans.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [fsms_pkg::CFG_IDX_W-1:0] idx,
                           logic [fsms_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      fsms_pkg::REG_MACHINES: cfg_machines = data[fsms_pkg::COUNT_W-1:0];
      fsms_pkg::REG_SETUPS:   cfg_setups   = data;
      fsms_pkg::REG_FACTOR:   cfg_factor   = data[fsms_pkg::BYTE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic job_t rand_job(logic start);
    job_t j;
    j.start = start;
    j.jtype = ($urandom_range(1) == 1) ? fsms_pkg::TYPE_W'($urandom_range(2))
                                       : fsms_pkg::TYPE_W'($urandom);
    for (int m = 0; m < fsms_pkg::NUM_PROC; m++) begin
      case ($urandom_range(9))
        0:       j.proc[m] = 8'h00;
        1:       j.proc[m] = 8'hff;
        default: j.proc[m] = fsms_pkg::BYTE_W'($urandom);
      endcase
    end
    return j;
  endfunction

  task automatic random_config();
    logic [fsms_pkg::COUNT_W-1:0]    nib;
    logic [fsms_pkg::CFG_DATA_W-1:0] word;
    logic [fsms_pkg::BYTE_W-1:0]     fac;
    nib = ($urandom_range(3) == 0) ? fsms_pkg::COUNT_W'($urandom_range(15))
                                   : fsms_pkg::COUNT_W'($urandom_range(8, 1));
    write_reg(fsms_pkg::REG_MACHINES, {32'($urandom), 28'($urandom), nib});
    word = '0;
    case ($urandom_range(2))
      0: word = {$urandom, $urandom};
      1: for (int b = 0; b < fsms_pkg::NUM_PROC; b++)
           word[b*fsms_pkg::BYTE_W +: fsms_pkg::BYTE_W] = 8'($urandom_range(7));
      default: ;
    endcase
    write_reg(fsms_pkg::REG_SETUPS, word);
    case ($urandom_range(3))
      0:       fac = 8'd0;
      1:       fac = 8'd1;
      2:       fac = 8'hff;
      default: fac = fsms_pkg::BYTE_W'($urandom);
    endcase
    write_reg(fsms_pkg::REG_FACTOR, {$urandom, 24'($urandom), fac});
    if ($urandom_range(3) == 0) write_reg(REG_SPARE, {$urandom, $urandom});
  endtask

  task automatic run_schedules(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(20, 1);
      for (int k = 0; k < len && sent < n_items; k++) begin
        send_job(rand_job((k == 0) || ($urandom_range(99) < 5)));
        sent++;
      end
    end
  endtask

  task automatic test_defaults();
    job_t j;
    j       = '0;
    j.start = 1'b1;
    j.proc  = '1;
    send_job(j);
    j.start = 1'b0;
    j.jtype = 8'hff;
    j.proc  = '0;
    send_job(j);
    j.jtype = 8'h80;
    j.proc  = 64'h0102_0408_1020_4080;
    send_job(j);
  endtask

  task automatic test_setups_and_types();
    job_t j;
    wait_drain();
    write_reg(fsms_pkg::REG_SETUPS, 64'h0807_0605_0403_0201);
    write_reg(fsms_pkg::REG_FACTOR, 64'd3);
    write_reg(fsms_pkg::REG_MACHINES, 64'd4);
    write_reg(REG_SPARE, 64'hdead_beef_0000_0001);
    // first job of a schedule still pays the base setup
    j = rand_job(1'b1);
    j.jtype = 8'd5;
    send_job(j);
    j = rand_job(1'b0);
    j.jtype = 8'd5;
    send_job(j);
    j = rand_job(1'b0);
    j.jtype = 8'd6;
    send_job(j);
    j = rand_job(1'b0);
    j.jtype = 8'd6;
    send_job(j);
    wait_drain();
    write_reg(fsms_pkg::REG_FACTOR, 64'hffff_ff00);
    j = rand_job(1'b0);
    j.jtype = 8'd7;
    send_job(j);
    // start flag clears the type history
    j = rand_job(1'b1);
    j.jtype = 8'd9;
    send_job(j);
  endtask

  task automatic test_machine_count();
    wait_drain();
    write_reg(fsms_pkg::REG_MACHINES, 64'd0);
    send_job(rand_job(1'b1));
    send_job(rand_job(1'b0));
    wait_drain();
    write_reg(fsms_pkg::REG_MACHINES, 64'd1);
    send_job(rand_job(1'b0));
    wait_drain();
    write_reg(fsms_pkg::REG_MACHINES, 64'hffff_ffff_ffff_fff0 | 64'd15);
    send_job(rand_job(1'b1));
    send_job(rand_job(1'b0));
    wait_drain();
    write_reg(fsms_pkg::REG_MACHINES, 64'd9);
    send_job(rand_job(1'b0));
    wait_drain();
    write_reg(fsms_pkg::REG_MACHINES, 64'd3);
    send_job(rand_job(1'b1));
    // count grows mid-schedule, upper machines keep old finishes
    wait_drain();
    write_reg(fsms_pkg::REG_MACHINES, 64'd8);
    send_job(rand_job(1'b0));
    send_job(rand_job(1'b0));
  endtask

  task automatic test_extremes();
    job_t j;
    wait_drain();
    write_reg(fsms_pkg::REG_SETUPS, '1);
    write_reg(fsms_pkg::REG_FACTOR, 64'd255);
    j       = '0;
    j.start = 1'b1;
    j.proc  = '1;
    send_job(j);
    j.start = 1'b0;
    j.jtype = 8'hff;
    send_job(j);
    j.jtype = 8'h00;
    j.proc  = '0;
    send_job(j);
  endtask

  task automatic test_saturation();
    job_t j;
    wait_drain();
    write_reg(fsms_pkg::REG_MACHINES, 64'd8);
    write_reg(fsms_pkg::REG_SETUPS, '1);
    write_reg(fsms_pkg::REG_FACTOR, 64'd255);
    j = rand_job(1'b1);
    send_job(j);
    // every job changes type so the multiplied setup piles up past the ceiling
    for (int i = 1; i < 300; i++) begin
      j = rand_job(1'b0);
      j.jtype = last_type ^ fsms_pkg::TYPE_W'($urandom_range(255, 1));
      send_job(j);
    end
    send_job(rand_job(1'b1));
    send_job(rand_job(1'b0));
  endtask

  task automatic test_random(int n_items);
    for (int p = 0; p < 5; p++) begin
      wait_drain();
      random_config();
      run_schedules(n_items / 5);
    end
  endtask

  task automatic test_backpressure();
    wait_drain();
    write_reg(fsms_pkg::REG_MACHINES, 64'd8);
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++) send_job(rand_job(i == 0));
    wait_drain();
    for (int i = 0; i < 4; i++) send_job(rand_job(1'b0));
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cfg_machines = fsms_pkg::MACHINES_RST;
    cfg_setups   = '0;
    cfg_factor   = fsms_pkg::FACTOR_RST;
    clear_line();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 23;
    recv_idle_pct = 53;
    test_defaults();
    test_setups_and_types();
    test_machine_count();
    test_extremes();
    test_random(110);

    send_idle_pct = 53;
    recv_idle_pct = 23;
    test_saturation();
    test_random(110);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(110);
    test_backpressure();

    wait_drain();
    if (error_count == 0) begin
      $display("flow_shop_makespan_with_setups_core test passed");
    end else begin
      $display("flow_shop_makespan_with_setups_core test failed");
    end
    $finish;
  end

endmodule

// File: flow_shop_makespan_with_setups_core.f
design/fsms_pkg.sv
design/fsms_ctrl.sv
design/fsms_alu.sv
design/flow_shop_makespan_with_setups_core.sv
tb/tb_top.sv
